FILE: hdl/slp_pkg.sv
// Shared types and constants for the sampled line projection unit.
// Used by the divider, controller, datapath and top level; no dependencies.
package slp_pkg;

  localparam int DIM_W       = 13;  // width and height registers
  localparam int LINES_W     = 6;   // sample line count registers
  localparam int SAMP_W      = LINES_W + 1;  // sample index, holds lines + 1
  localparam int PIX_W       = 8;
  localparam int SUM_W       = 20;
  localparam int POS_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int DIV_STEP_W  = $clog2(DIM_W + 1);
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_MAX_SAMPLES = 32;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LINES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_LINES    = 3'd3;

  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
  localparam logic [LINES_W-1:0] LINES_RESET  = 6'd4;

  typedef enum logic [2:0] {
    ST_SETUP,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_RUN,
    ST_EMIT_ROW,
    ST_EMIT_COL,
    ST_EMIT_ERR
  } slp_state_e;

  typedef struct packed {
    logic setup;         // frame start: clear sums, start row spacing divide
    logic col_div;       // start column spacing divide
    logic store_row_sp;
    logic store_col_sp;
    logic accept;        // pixel taken this cycle
    logic emit_row;
    logic emit_col;
    logic emit_err;
    logic last;
  } slp_cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic div_done;
    logic row_emit;      // accepted pixel closes a sample row
    logic frame_end;     // accepted pixel closes the frame
    logic cols_zero;
    logic drain_last;
  } slp_status_t;

endpackage

FILE: hdl/sampled_line_projection_unit.sv
// Top level of the sampled line projection unit: stream ports, config port.
// Depends on slp_pkg, slp_ctrl and slp_datapath.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+--------------------------------
//  pixels    | in  | s_axis_tvalid / s_axis_tready | tdata: pixel
//  results   | out | m_axis_tvalid / m_axis_tready | tdata: line_position, line_sum;
//            |     |                               | tuser: axis, status; tlast: last
//  config    | in  | cfg_we_i                      | cfg_idx_i, cfg_data_i
//
// One pixel per cycle within a frame while no results are being emitted.
// At each frame start the two spacings come one after the other from one
// shared bit-serial divider before the first pixel is taken; both divides are
// skipped when the configuration is invalid. A pixel that produces results holds
// the input while they go out (up to 32 at frame end) and while m_axis_tready is low.
// Reset or any config write restarts the frame.
module sampled_line_projection_unit import slp_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [12:0] line_position, [32:13] line_sum
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] axis, [1] status
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DIM_W-1:0]       cfg_data_i
);

  slp_cmd_t         cmd;
  slp_status_t      status;
  logic             out_axis, out_status, out_last;
  logic [POS_W-1:0] out_pos;
  logic [SUM_W-1:0] out_sum;

  slp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  slp_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .pixel_i      (s_axis_tdata[PIX_W-1:0]),
    .out_axis_o   (out_axis),
    .out_pos_o    (out_pos),
    .out_sum_o    (out_sum),
    .out_status_o (out_status),
    .out_last_o   (out_last)
  );

  assign m_axis_tdata = OUT_TDATA_W'({out_sum, out_pos});
  assign m_axis_tuser = {out_status, out_axis};
  assign m_axis_tlast = out_last;

`ifndef SYNTHESIS
  // a result word is never written over one still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_row || cmd.emit_col || cmd.emit_err) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result word overwritten while stalled");

  // pixel intake and result emission never share a cycle
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.emit_row, cmd.emit_col, cmd.emit_err}))
    else $error("more than one datapath operation in a cycle");

  // the pixel after a frame end waits for frame setup
  a_frame_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && status.frame_end) |=> !s_axis_tready)
    else $error("pixel taken right after frame end");

  // a register write always restarts setup
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input open right after config write");
`endif

endmodule

FILE: hdl/slp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on slp_pkg for operand widths.
module slp_div import slp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIM_W-1:0]  dividend_i,
  input  logic [SAMP_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIM_W-1:0]  quotient_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic [SAMP_W-1:0]     rem_q;
  logic [SAMP_W-1:0]     dsr_q;
  logic [DIM_W-1:0]      quo_q;
  logic [SAMP_W:0]       trial;
  logic [SAMP_W:0]       diff;
  logic                  fits;

  // quotient bits shift in at the bottom as dividend bits leave at the top
  assign trial = {rem_q, quo_q[DIM_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = DIV_STEP_W'(DIM_W);
    end else if (busy_q) begin
      step_d = step_q - DIV_STEP_W'(1);
      if (step_q == DIV_STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[SAMP_W-1:0] : trial[SAMP_W-1:0];
      quo_q <= {quo_q[DIM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hdl/slp_datapath.sv
// Datapath: config registers, raster counters, row accumulator, column sums,
// spacing divider and output word register. Depends on slp_pkg and slp_div.
module slp_datapath import slp_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  slp_cmd_t             cmd_i,
  output slp_status_t          status_o,
  input  logic [PIX_W-1:0]     pixel_i,
  output logic                 out_axis_o,
  output logic [POS_W-1:0]     out_pos_o,
  output logic [SUM_W-1:0]     out_sum_o,
  output logic                 out_status_o,
  output logic                 out_last_o
);

  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam int WMAX    = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int HMAX    = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam int CW      = $clog2(WMAX);
  localparam int RW      = $clog2(HMAX);
  localparam int CSP_W   = $clog2(WMAX + 1);
  localparam int RSP_W   = $clog2(HMAX + 1);
  localparam int IDX_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [DIM_W-1:0]   W_CLAMP = DIM_W'(WMAX);
  localparam logic [DIM_W-1:0]   H_CLAMP = DIM_W'(HMAX);
  localparam logic [LINES_W-1:0] S_LIMIT = LINES_W'(MAX_SAMPLES);

  logic [DIM_W-1:0]   width_q, height_q;
  logic [LINES_W-1:0] row_lines_q, col_lines_q;

  logic [RW-1:0]      row_cnt_q;
  logic [CW-1:0]      col_cnt_q;
  logic [RSP_W-1:0]   row_sp_q;
  logic [CSP_W-1:0]   col_sp_q;
  logic [POS_W-1:0]   row_pos_q, col_pos_q;
  logic [SAMP_W-1:0]  nrs_q, kc_q;
  logic [SUM_W-1:0]   row_acc_q;
  logic [CW-1:0]      cph_q;
  logic [IDX_W-1:0]   dk_q;
  logic [SUM_W-1:0]   sums_q [MAX_SAMPLES];

  logic               out_axis_q, out_status_q, out_last_q;
  logic [POS_W-1:0]   out_pos_q;
  logic [SUM_W-1:0]   out_sum_q;

  logic [DIM_W-1:0]   eff_w, eff_h;
  logic               frame_ok, row_end, frame_end, in_row, col_hit, col_take;
  logic [IDX_W-1:0]   rd_idx;
  logic [SUM_W-1:0]   rd_sum;
  logic [SUM_W:0]     row_add, col_add;
  logic [SUM_W-1:0]   row_new, col_new;
  logic               div_start, div_done;
  logic [DIM_W-1:0]   div_dividend, quo;
  logic [SAMP_W-1:0]  div_divisor;

  // ---- configuration registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      row_lines_q <= LINES_RESET;
      col_lines_q <= LINES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q     <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q    <= cfg_data_i;
        REG_ROW_LINES:    row_lines_q <= cfg_data_i[LINES_W-1:0];
        REG_COL_LINES:    col_lines_q <= cfg_data_i[LINES_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (width_q == '0)         eff_w = DIM_W'(1);
    else if (width_q > W_CLAMP) eff_w = W_CLAMP;
    else                        eff_w = width_q;
    if (height_q == '0)          eff_h = DIM_W'(1);
    else if (height_q > H_CLAMP) eff_h = H_CLAMP;
    else                         eff_h = height_q;
  end

  assign frame_ok = (DIM_W'(row_lines_q) < eff_h) && (DIM_W'(col_lines_q) < eff_w) &&
                    (row_lines_q <= S_LIMIT) && (col_lines_q <= S_LIMIT);

  // ---- spacing divider ----
  assign div_start    = cmd_i.setup | cmd_i.col_div;
  assign div_dividend = cmd_i.col_div ? eff_w : eff_h;
  assign div_divisor  = cmd_i.col_div ? SAMP_W'(col_lines_q) + SAMP_W'(1)
                                      : SAMP_W'(row_lines_q) + SAMP_W'(1);

  slp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // ---- per pixel decode ----
  assign row_end   = (DIM_W'(col_cnt_q) + DIM_W'(1)) >= eff_w;
  assign frame_end = row_end && ((DIM_W'(row_cnt_q) + DIM_W'(1)) >= eff_h);
  assign in_row    = (nrs_q <= SAMP_W'(row_lines_q)) &&
                     ((POS_W'(row_cnt_q) + POS_W'(1)) == row_pos_q);
  // cph counts pixels since the row start or the last column sample position in this row
  assign col_hit   = (CSP_W'(cph_q) + CSP_W'(1)) == col_sp_q;
  assign col_take  = frame_ok && col_hit && (kc_q <= SAMP_W'(col_lines_q));

  // single read port: drain index while emitting columns, else sample index
  assign rd_idx  = cmd_i.emit_col ? dk_q : IDX_W'(kc_q - SAMP_W'(1));
  assign rd_sum  = sums_q[rd_idx];

  assign row_add = {1'b0, row_acc_q} + (SUM_W+1)'(pixel_i);
  assign col_add = {1'b0, rd_sum} + (SUM_W+1)'(pixel_i);
  assign row_new = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
  assign col_new = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];

  // ---- raster counters ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (cfg_we_i) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (cmd_i.accept) begin
      if (row_end) begin
        col_cnt_q <= '0;
        row_cnt_q <= frame_end ? '0 : row_cnt_q + RW'(1);
      end else begin
        col_cnt_q <= col_cnt_q + CW'(1);
      end
    end
  end

  // ---- sample state, sums and output word ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      row_acc_q <= '0;
      nrs_q     <= SAMP_W'(1);
      cph_q     <= '0;
      kc_q      <= SAMP_W'(1);
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        sums_q[i] <= '0;
      end
    end
    if (cmd_i.store_row_sp) begin
      row_sp_q  <= RSP_W'(quo);
      row_pos_q <= POS_W'(quo);
    end
    if (cmd_i.store_col_sp) begin
      col_sp_q  <= CSP_W'(quo);
      col_pos_q <= POS_W'(quo);
      dk_q      <= '0;
    end
    if (cmd_i.accept) begin
      if (frame_ok && in_row) begin
        row_acc_q <= row_new;
      end
      if (col_take) begin
        sums_q[rd_idx] <= col_new;
      end
      if (row_end) begin
        cph_q <= '0;
        kc_q  <= SAMP_W'(1);
      end else if (col_hit) begin
        cph_q <= '0;
        if (kc_q <= SAMP_W'(col_lines_q)) begin
          kc_q <= kc_q + SAMP_W'(1);
        end
      end else begin
        cph_q <= cph_q + CW'(1);
      end
    end
    if (cmd_i.emit_row) begin
      out_axis_q   <= 1'b0;
      out_pos_q    <= row_pos_q;
      out_sum_q    <= row_acc_q;
      out_status_q <= 1'b0;
      out_last_q   <= cmd_i.last;
      row_acc_q    <= '0;
      nrs_q        <= nrs_q + SAMP_W'(1);
      row_pos_q    <= row_pos_q + POS_W'(row_sp_q);
    end
    if (cmd_i.emit_col) begin
      out_axis_q   <= 1'b1;
      out_pos_q    <= col_pos_q;
      out_sum_q    <= rd_sum;
      out_status_q <= 1'b0;
      out_last_q   <= cmd_i.last;
      dk_q         <= dk_q + IDX_W'(1);
      col_pos_q    <= col_pos_q + POS_W'(col_sp_q);
    end
    if (cmd_i.emit_err) begin
      out_axis_q   <= 1'b0;
      out_pos_q    <= '0;
      out_sum_q    <= '0;
      out_status_q <= 1'b1;
      out_last_q   <= cmd_i.last;
    end
  end

  assign status_o.frame_ok   = frame_ok;
  assign status_o.div_done   = div_done;
  assign status_o.row_emit   = frame_ok && in_row && row_end;
  assign status_o.frame_end  = frame_end;
  assign status_o.cols_zero  = (col_lines_q == '0);
  assign status_o.drain_last = (SAMP_W'(dk_q) + SAMP_W'(1)) == SAMP_W'(col_lines_q);

  assign out_axis_o   = out_axis_q;
  assign out_pos_o    = out_pos_q;
  assign out_sum_o    = out_sum_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

FILE: hdl/slp_ctrl.sv
// Controller: frame setup sequencing, pixel acceptance and result emission.
// Depends on slp_pkg for the state enum and command/status structs.
module slp_ctrl import slp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic        m_ready_i,
  output logic        m_valid_o,
  input  slp_status_t status_i,
  output slp_cmd_t    cmd_o
);

  slp_state_e state_q, state_d;
  logic       frame_end_q, frame_end_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, load;

  assign out_free = !out_valid_q || m_ready_i;

  // next state
  always_comb begin
    state_d     = state_q;
    frame_end_d = frame_end_q;
    case (state_q)
      ST_SETUP: begin
        state_d = status_i.frame_ok ? ST_DIV_ROW : ST_RUN;
      end
      ST_DIV_ROW: begin
        if (status_i.div_done) state_d = ST_DIV_COL;
      end
      ST_DIV_COL: begin
        if (status_i.div_done) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (s_valid_i) begin
          frame_end_d = status_i.frame_end;
          if (status_i.row_emit) begin
            state_d = ST_EMIT_ROW;
          end else if (status_i.frame_end) begin
            if (!status_i.frame_ok)      state_d = ST_EMIT_ERR;
            else if (status_i.cols_zero) state_d = ST_SETUP;
            else                         state_d = ST_EMIT_COL;
          end
        end
      end
      ST_EMIT_ROW: begin
        if (out_free) begin
          if (!frame_end_q)            state_d = ST_RUN;
          else if (status_i.cols_zero) state_d = ST_SETUP;
          else                         state_d = ST_EMIT_COL;
        end
      end
      ST_EMIT_COL: begin
        if (out_free && status_i.drain_last) state_d = ST_SETUP;
      end
      ST_EMIT_ERR: begin
        if (out_free) state_d = ST_SETUP;
      end
      default: state_d = ST_SETUP;
    endcase
    // any register write restarts the frame
    if (cfg_we_i) state_d = ST_SETUP;
  end

  // outputs
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      ST_DIV_ROW: begin
        cmd_o.store_row_sp = status_i.div_done;
        cmd_o.col_div      = status_i.div_done;
      end
      ST_DIV_COL: begin
        cmd_o.store_col_sp = status_i.div_done;
      end
      ST_RUN: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
      end
      ST_EMIT_ROW: begin
        cmd_o.emit_row = out_free;
        cmd_o.last     = !(frame_end_q && !status_i.cols_zero);
      end
      ST_EMIT_COL: begin
        cmd_o.emit_col = out_free;
        cmd_o.last     = status_i.drain_last;
      end
      ST_EMIT_ERR: begin
        cmd_o.emit_err = out_free;
        cmd_o.last     = 1'b1;
      end
      default: ;
    endcase
  end

  assign load        = cmd_o.emit_row | cmd_o.emit_col | cmd_o.emit_err;
  assign out_valid_d = load ? 1'b1 : (m_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SETUP;
      frame_end_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_end_q <= frame_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule
